// File: sv/fspc_pkg.sv
// Package for the five-stage pipelined teaching CPU.
// Holds item types, opcodes, command codes, controller state and decode helpers.
// No dependencies.
package fspc_pkg;

  localparam int MEM_AW = 10;
  localparam logic [31:0] NOOP_WORD = 32'h01c0_0000;

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_NOR  = 3'd1;
  localparam logic [2:0] OP_LW   = 3'd2;
  localparam logic [2:0] OP_SW   = 3'd3;
  localparam logic [2:0] OP_BEQ  = 3'd4;
  localparam logic [2:0] OP_HALT = 3'd6;

  localparam logic [1:0] FN_LOAD = 2'd0;
  localparam logic [1:0] FN_TICK = 2'd1;
  localparam logic [1:0] FN_RMEM = 2'd2;
  localparam logic [1:0] FN_RREG = 2'd3;

  typedef struct packed {
    logic [1:0]         func;
    logic [9:0]         address;
    logic signed [31:0] data;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] read_data;
    logic [9:0]         pc_now;
    logic [31:0]        cycle_count;
    logic               halted;
    logic               wb_valid;
    logic [2:0]         wb_reg;
    logic signed [31:0] wb_value;
    logic               stalled;
    logic               flushed;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_HOLD
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic exec;
  } ctrl_cmd_t;

  function automatic logic [2:0] op_of(input logic [31:0] w);
    return w[24:22];
  endfunction

  function automatic logic [2:0] ra_of(input logic [31:0] w);
    return w[21:19];
  endfunction

  function automatic logic [2:0] rb_of(input logic [31:0] w);
    return w[18:16];
  endfunction

  function automatic logic writes_reg(input logic [31:0] w);
    return (w[24:22] == OP_ADD) || (w[24:22] == OP_NOR) || (w[24:22] == OP_LW);
  endfunction

  function automatic logic [2:0] dest_of(input logic [31:0] w);
    return (w[24:22] == OP_LW) ? w[18:16] : w[2:0];
  endfunction

endpackage

// File: sv/fspc_ctrl.sv
// Controller state machine for the pipelined CPU block.
// Sequences accept, execute and result hand-off. Depends on fspc_pkg.
module fspc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output fspc_pkg::ctrl_cmd_t cmd
);
  import fspc_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    cmd.accept = 1'b0;
    cmd.exec   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = ST_HOLD;
      end
      ST_HOLD: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// File: sv/fspc_datapath.sv
// Datapath of the pipelined CPU: memories, register file, pipeline latches.
// Runs one machine cycle per execute command of a tick request while not halted. Depends on fspc_pkg.
module fspc_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fspc_pkg::ctrl_cmd_t  cmd,
  input  fspc_pkg::in_item_t   in_item,
  output fspc_pkg::out_item_t  out_item
);
  import fspc_pkg::*;

  localparam int MEM_WORDS = 1 << MEM_AW;

  logic [31:0] imem [MEM_WORDS];
  logic [31:0] dmem [MEM_WORDS];
  logic [31:0] imem_q_r, dmem_q_r;
  logic [31:0] rf_r [8];
  in_item_t    req_r;
  out_item_t   res_r;

  logic [9:0]  pc_r;
  logic [31:0] fd_w_r, de_w_r, em_w_r, mw_w_r, we_w_r;
  logic [9:0]  fd_pc_r, de_pc_r;
  logic [31:0] de_a_r, de_b_r, de_off_r;
  logic [31:0] em_t_r, em_alu_r, em_st_r, mw_v_r, we_v_r, cyc_r;
  logic        halt_r;

  logic [9:0]  pc_nxt, fd_pc_nxt, de_pc_nxt;
  logic [31:0] fd_w_nxt, de_w_nxt, em_w_nxt;
  logic [31:0] de_a_nxt, de_b_nxt, de_off_nxt;
  logic [31:0] em_t_nxt, em_alu_nxt, em_st_nxt, mw_v_nxt;
  logic [31:0] fa, fb;
  logic        stl, fl, wbv, run;
  logic [MEM_AW-1:0] rd_addr;

  assign run     = cmd.exec && (req_r.func == FN_TICK) && !halt_r;
  assign rd_addr = (in_item.func == FN_RMEM) ? in_item.address[MEM_AW-1:0]
                                              : em_alu_r[MEM_AW-1:0];
  assign wbv     = writes_reg(mw_w_r);

  always_ff @(posedge clk) begin
    if (cmd.accept && in_item.func == FN_LOAD) begin
      imem[in_item.address[MEM_AW-1:0]] <= in_item.data;
    end
    if (cmd.accept) begin
      imem_q_r <= imem[pc_r[MEM_AW-1:0]];
      req_r    <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && in_item.func == FN_LOAD) begin
      dmem[in_item.address[MEM_AW-1:0]] <= in_item.data;
    end else if (run && op_of(em_w_r) == OP_SW) begin
      dmem[em_alu_r[MEM_AW-1:0]] <= em_st_r;
    end
    if (cmd.accept) begin
      dmem_q_r <= dmem[rd_addr];
    end
  end

  always_comb begin
    pc_nxt    = pc_r + 10'd1;
    fd_w_nxt  = imem_q_r;
    fd_pc_nxt = pc_nxt;
    de_w_nxt  = fd_w_r;
    de_pc_nxt = fd_pc_r;
    de_a_nxt  = de_a_r;
    de_b_nxt  = de_b_r;
    de_off_nxt = de_off_r;
    stl = 1'b0;
    fl  = 1'b0;
    if (op_of(de_w_r) == OP_LW &&
        (ra_of(fd_w_r) == rb_of(de_w_r) || rb_of(fd_w_r) == rb_of(de_w_r))) begin
      stl       = 1'b1;
      de_w_nxt  = NOOP_WORD;
      pc_nxt    = pc_r;
      fd_w_nxt  = fd_w_r;
      fd_pc_nxt = fd_pc_r;
    end else begin
      de_off_nxt = {{16{fd_w_r[15]}}, fd_w_r[15:0]};
      de_a_nxt   = rf_r[ra_of(fd_w_r)];
      de_b_nxt   = rf_r[rb_of(fd_w_r)];
    end

    em_w_nxt = de_w_r;
    em_t_nxt = {22'd0, de_pc_r} + de_off_r;
    fa = de_a_r;
    fb = de_b_r;
    if (writes_reg(we_w_r)) begin
      if (ra_of(de_w_r) == dest_of(we_w_r)) fa = we_v_r;
      if (rb_of(de_w_r) == dest_of(we_w_r)) fb = we_v_r;
    end
    if (writes_reg(mw_w_r)) begin
      if (ra_of(de_w_r) == dest_of(mw_w_r)) fa = mw_v_r;
      if (rb_of(de_w_r) == dest_of(mw_w_r)) fb = mw_v_r;
    end
    if (writes_reg(em_w_r)) begin
      if (ra_of(de_w_r) == dest_of(em_w_r)) fa = em_alu_r;
      if (rb_of(de_w_r) == dest_of(em_w_r)) fb = em_alu_r;
    end
    em_alu_nxt = em_alu_r;
    em_st_nxt  = em_st_r;
    case (op_of(de_w_r))
      OP_LW, OP_SW: em_alu_nxt = fa + de_off_r;
      OP_NOR:       em_alu_nxt = ~(fa | fb);
      OP_ADD:       em_alu_nxt = fa + fb;
      OP_BEQ:       em_alu_nxt = fa - fb;
      default:      em_alu_nxt = em_alu_r;
    endcase
    if (op_of(de_w_r) <= OP_BEQ) em_st_nxt = fb;

    mw_v_nxt = mw_v_r;
    case (op_of(em_w_r))
      OP_LW: mw_v_nxt = dmem_q_r;
      OP_BEQ: begin
        if (em_alu_r == 32'd0) begin
          fl       = 1'b1;
          pc_nxt   = em_t_r[9:0];
          fd_w_nxt = NOOP_WORD;
          de_w_nxt = NOOP_WORD;
          em_w_nxt = NOOP_WORD;
        end
      end
      OP_ADD, OP_NOR: mw_v_nxt = em_alu_r;
      default: mw_v_nxt = mw_v_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0; fd_w_r <= NOOP_WORD; fd_pc_r <= '0;
      de_w_r <= NOOP_WORD; de_pc_r <= '0; de_a_r <= '0; de_b_r <= '0; de_off_r <= '0;
      em_w_r <= NOOP_WORD; em_t_r <= '0; em_alu_r <= '0; em_st_r <= '0;
      mw_w_r <= NOOP_WORD; mw_v_r <= '0; we_w_r <= NOOP_WORD; we_v_r <= '0;
      cyc_r <= '0; halt_r <= 1'b0;
      for (int i = 0; i < 8; i++) rf_r[i] <= '0;
    end else if (run) begin
      pc_r <= pc_nxt; fd_w_r <= fd_w_nxt; fd_pc_r <= fd_pc_nxt;
      de_w_r <= de_w_nxt; de_pc_r <= de_pc_nxt;
      de_a_r <= de_a_nxt; de_b_r <= de_b_nxt; de_off_r <= de_off_nxt;
      em_w_r <= em_w_nxt; em_t_r <= em_t_nxt; em_alu_r <= em_alu_nxt; em_st_r <= em_st_nxt;
      mw_w_r <= em_w_r; mw_v_r <= mw_v_nxt; we_w_r <= mw_w_r; we_v_r <= mw_v_r;
      cyc_r <= cyc_r + 32'd1;
      if (op_of(em_w_r) == OP_HALT) halt_r <= 1'b1;
      if (wbv) rf_r[dest_of(mw_w_r)] <= mw_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_r.read_data   <= (req_r.func == FN_RMEM) ? dmem_q_r :
                           (req_r.func == FN_RREG) ? rf_r[req_r.address[2:0]] : 32'd0;
      res_r.pc_now      <= run ? pc_nxt : pc_r;
      res_r.cycle_count <= run ? cyc_r + 32'd1 : cyc_r;
      res_r.halted      <= halt_r || (run && op_of(em_w_r) == OP_HALT);
      res_r.wb_valid    <= run && wbv;
      res_r.wb_reg      <= (run && wbv) ? dest_of(mw_w_r) : 3'd0;
      res_r.wb_value    <= (run && wbv) ? mw_v_r : 32'd0;
      res_r.stalled     <= run && stl;
      res_r.flushed     <= run && fl;
    end
  end

  assign out_item = res_r;

endmodule

// File: sv/five_stage_pipeline_forwarding_cpu_top.sv
// Top level of the five-stage pipelined teaching CPU block.
// Instantiates fspc_ctrl and fspc_datapath. Depends on fspc_pkg.
//
// One input transaction carries a command: load a program word into both
// memories, run one machine cycle, read a data memory word, or read a
// register. Each input transaction yields exactly one result transaction
// with the read word, program counter, cycle count, halt flag, the register
// write of the cycle and the stall and flush flags.
// Inputs are taken while in_stall is low; the result is registered in the
// execute state, offered in the hold state and held on out_item while
// out_stall is high. A new transaction is taken the cycle after the result
// leaves, so the block takes no new item before the last result has left.
// Reset (rst_n low, synchronous) clears the pipeline to noops, the program
// counter, registers, cycle count and halt flag. Memories are not cleared
// and must be loaded before they are fetched or read.
module five_stage_pipeline_forwarding_cpu_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fspc_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output fspc_pkg::out_item_t out_item
);
  import fspc_pkg::*;

  ctrl_cmd_t cmd;

  fspc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  fspc_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .out_item (out_item)
  );

endmodule

// File: tb/sv/five_stage_pipeline_forwarding_cpu_top_test.sv
// Self-checking testbench for five_stage_pipeline_forwarding_cpu_top.
// Holds a cycle-level predictor of the pipelined CPU, random stimulus and a result checker.
// Depends on fspc_pkg and the RTL of the block.
module five_stage_pipeline_forwarding_cpu_top_test;
  import fspc_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int LONG_HOLD = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;

  five_stage_pipeline_forwarding_cpu_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // CPU state as the predictor sees it.
  logic [9:0] cpu_pc;
  logic [31:0] cpu_regs [8];
  logic [31:0] cpu_imem [1024];
  logic [31:0] cpu_dmem [1024];
  logic [31:0] fd_word, de_word, em_word, mw_word, we_word;
  logic [9:0] fd_npc, de_npc;
  logic [31:0] de_a, de_b, de_off, em_target, em_alu, em_store, mw_value, we_value;
  logic [31:0] cpu_cycles;
  logic cpu_halted;

  out_item_t cpu_results [$];
  int errors = 0;
  int cycles = 0;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int rx_wait = 0;

  function automatic logic dest_write(input logic [31:0] w);
    return (w[24:22] == OP_ADD) || (w[24:22] == OP_NOR) || (w[24:22] == OP_LW);
  endfunction

  function automatic logic [2:0] dest_reg(input logic [31:0] w);
    return (w[24:22] == OP_LW) ? w[18:16] : w[2:0];
  endfunction

  function automatic logic [31:0] instr(input logic [2:0] op, input logic [2:0] ra,
                                        input logic [2:0] rb, input logic [15:0] off);
    return {7'($urandom), op, ra, rb, off};
  endfunction

  function automatic logic [31:0] random_instr();
    logic [2:0] op;
    logic [15:0] off;
    op = 3'($urandom_range(0, 6));
    if (op == OP_HALT) op = 3'd7;
    off = ($urandom_range(0, 9) < 3) ? 16'($urandom) : 16'($urandom_range(0, 16) - 8);
    return instr(op, 3'($urandom), 3'($urandom), off);
  endfunction

  task automatic cpu_reset();
    cpu_pc = '0;
    foreach (cpu_regs[i]) cpu_regs[i] = '0;
    fd_word = NOOP_WORD; de_word = NOOP_WORD; em_word = NOOP_WORD;
    mw_word = NOOP_WORD; we_word = NOOP_WORD;
    fd_npc = '0; de_npc = '0;
    de_a = '0; de_b = '0; de_off = '0; em_target = '0; em_alu = '0; em_store = '0;
    mw_value = '0; we_value = '0; cpu_cycles = '0; cpu_halted = 1'b0;
  endtask

  task automatic cpu_step(input in_item_t it, output out_item_t r);
    logic [9:0] n_pc, n_fpc, n_dpc;
    logic [31:0] n_fw, n_dw, n_da, n_db, n_doff, n_ew, n_et, n_ealu, n_est, n_mw, n_mv;
    logic [31:0] a, b;
    logic [2:0] ea, eb, op;
    r = '0;
    case (it.func)
      FN_LOAD: begin
        cpu_imem[it.address] = it.data;
        cpu_dmem[it.address] = it.data;
      end
      FN_RMEM: r.read_data = cpu_dmem[it.address];
      FN_RREG: r.read_data = cpu_regs[it.address[2:0]];
      default: begin
        if (!cpu_halted) begin
          n_pc = cpu_pc + 10'd1;
          n_fw = cpu_imem[cpu_pc];
          n_fpc = n_pc;
          n_dw = fd_word; n_dpc = fd_npc; n_da = de_a; n_db = de_b; n_doff = de_off;
          if (de_word[24:22] == OP_LW &&
              (fd_word[21:19] == de_word[18:16] || fd_word[18:16] == de_word[18:16])) begin
            r.stalled = 1'b1;
            n_dw = NOOP_WORD;
            n_pc = cpu_pc;
            n_fw = fd_word;
            n_fpc = fd_npc;
          end else begin
            n_doff = {{16{fd_word[15]}}, fd_word[15:0]};
            n_da = cpu_regs[fd_word[21:19]];
            n_db = cpu_regs[fd_word[18:16]];
          end
          n_ew = de_word;
          n_et = 32'(de_npc) + de_off;
          a = de_a; b = de_b;
          ea = de_word[21:19]; eb = de_word[18:16];
          if (dest_write(we_word)) begin
            if (ea == dest_reg(we_word)) a = we_value;
            if (eb == dest_reg(we_word)) b = we_value;
          end
          if (dest_write(mw_word)) begin
            if (ea == dest_reg(mw_word)) a = mw_value;
            if (eb == dest_reg(mw_word)) b = mw_value;
          end
          if (dest_write(em_word)) begin
            if (ea == dest_reg(em_word)) a = em_alu;
            if (eb == dest_reg(em_word)) b = em_alu;
          end
          n_ealu = em_alu; n_est = em_store;
          op = de_word[24:22];
          if (op == OP_LW || op == OP_SW) n_ealu = a + de_off;
          else if (op == OP_NOR) n_ealu = ~(a | b);
          else if (op == OP_ADD) n_ealu = a + b;
          else if (op == OP_BEQ) n_ealu = a - b;
          if (op <= OP_BEQ) n_est = b;
          n_mw = em_word; n_mv = mw_value;
          op = em_word[24:22];
          if (op == OP_LW) begin
            n_mv = cpu_dmem[em_alu[9:0]];
          end else if (op == OP_BEQ) begin
            if (em_alu == 32'd0) begin
              r.flushed = 1'b1;
              n_pc = em_target[9:0];
              n_fw = NOOP_WORD; n_dw = NOOP_WORD; n_ew = NOOP_WORD;
            end
          end else if (op == OP_SW) begin
            cpu_dmem[em_alu[9:0]] = em_store;
          end else if (op == OP_ADD || op == OP_NOR) begin
            n_mv = em_alu;
          end
          if (dest_write(mw_word)) begin
            r.wb_valid = 1'b1;
            r.wb_reg = dest_reg(mw_word);
            r.wb_value = mw_value;
            cpu_regs[dest_reg(mw_word)] = mw_value;
          end
          we_word = mw_word; we_value = mw_value;
          cpu_pc = n_pc;
          fd_word = n_fw; fd_npc = n_fpc;
          de_word = n_dw; de_npc = n_dpc; de_a = n_da; de_b = n_db; de_off = n_doff;
          em_word = n_ew; em_target = n_et; em_alu = n_ealu; em_store = n_est;
          mw_word = n_mw; mw_value = n_mv;
          cpu_cycles = cpu_cycles + 32'd1;
          if (mw_word[24:22] == OP_HALT) cpu_halted = 1'b1;
        end
      end
    endcase
    r.pc_now = cpu_pc;
    r.cycle_count = cpu_cycles;
    r.halted = cpu_halted;
  endtask

  task automatic send_item(input logic [1:0] func, input logic [9:0] addr,
                           input logic [31:0] data);
    int gap;
    in_item_t it;
    out_item_t r;
    gap = tx_idle ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.func = func; it.address = addr; it.data = data;
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    cpu_step(it, r);
    cpu_results.push_back(r);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (cpu_results.size() > 0) @(posedge clk);
  endtask

  task automatic test_fill_memory();
    for (int i = 0; i < 1024; i++) begin
      if (i == 1) send_item(FN_LOAD, 10'(i), 32'h8000_0000);
      else if (i == 2) send_item(FN_LOAD, 10'(i), 32'h7fff_ffff);
      else send_item(FN_LOAD, 10'(i), random_instr());
    end
  endtask

  task automatic test_directed_program();
    send_item(FN_LOAD, 10'd0, instr(OP_LW, 3'd0, 3'd1, 16'd20));
    send_item(FN_LOAD, 10'd1, instr(OP_ADD, 3'd1, 3'd1, 16'd2));
    send_item(FN_LOAD, 10'd2, instr(OP_NOR, 3'd2, 3'd1, 16'd3));
    send_item(FN_LOAD, 10'd3, instr(OP_ADD, 3'd3, 3'd2, 16'd4));
    send_item(FN_LOAD, 10'd4, instr(OP_SW, 3'd0, 3'd4, 16'd21));
    send_item(FN_LOAD, 10'd5, instr(OP_BEQ, 3'd0, 3'd0, 16'd3));
    send_item(FN_LOAD, 10'd9, instr(3'd5, 3'd1, 3'd2, 16'hffff));
    send_item(FN_LOAD, 10'd10, instr(OP_LW, 3'd0, 3'd5, 16'hffff));
    send_item(FN_LOAD, 10'd20, 32'h7fff_ffff);
    repeat (13) send_item(FN_TICK, 10'h3ff, 32'hffff_ffff);
    send_item(FN_RMEM, 10'd21, '0);
    send_item(FN_RMEM, 10'h3ff, '0);
    send_item(FN_RREG, 10'h3fc, '0);
  endtask

  task automatic test_random_mix(input int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) begin
        tx_idle = $urandom_range(0, 3) != 0;
        rx_idle = $urandom_range(0, 3) != 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) send_item(FN_TICK, 10'($urandom), $urandom);
      else if (pick < 82) send_item(FN_LOAD, 10'($urandom), random_instr());
      else if (pick < 91) send_item(FN_RMEM, 10'($urandom), $urandom);
      else send_item(FN_RREG, 10'($urandom), $urandom);
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  task automatic test_backpressure();
    tx_idle = 1'b0;
    hold_req++;
    repeat (40) send_item(FN_TICK, 10'($urandom), $urandom);
    tx_idle = 1'b1;
  endtask

  task automatic test_pause_until_drained();
    wait_drained();
    repeat (10) send_item(FN_RREG, 10'($urandom), $urandom);
  endtask

  task automatic test_halt();
    while (!cpu_halted) begin
      send_item(FN_LOAD, cpu_pc, instr(OP_HALT, 3'($urandom), 3'($urandom), 16'($urandom)));
      send_item(FN_TICK, 10'($urandom), $urandom);
    end
    repeat (4) send_item(FN_TICK, 10'($urandom), $urandom);
    send_item(FN_RREG, 10'd7, '0);
  endtask

  task automatic check_field(input string name, input logic [31:0] expected,
                             input logic [31:0] actual);
    if (expected !== actual) begin
      $error("%s: expected %h, got %h", name, expected, actual);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (cpu_results.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        e = cpu_results.pop_front();
        check_field("read_data", e.read_data, out_item.read_data);
        check_field("pc_now", 32'(e.pc_now), 32'(out_item.pc_now));
        check_field("cycle_count", e.cycle_count, out_item.cycle_count);
        check_field("halted", 32'(e.halted), 32'(out_item.halted));
        check_field("wb_valid", 32'(e.wb_valid), 32'(out_item.wb_valid));
        check_field("wb_reg", 32'(e.wb_reg), 32'(out_item.wb_reg));
        check_field("wb_value", e.wb_value, out_item.wb_value);
        check_field("stalled", 32'(e.stalled), 32'(out_item.stalled));
        check_field("flushed", 32'(e.flushed), 32'(out_item.flushed));
      end
    end
  end

  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = LONG_HOLD;
    end
    if (out_valid && !out_stall) rx_wait = rx_idle ? $urandom_range(0, 11) : 0;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    cpu_reset();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fill_memory();
    test_directed_program();
    test_random_mix(300);
    test_backpressure();
    test_pause_until_drained();
    test_random_mix(250);
    test_halt();
    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// File: filelist.f
sv/fspc_pkg.sv
sv/fspc_ctrl.sv
sv/fspc_datapath.sv
sv/five_stage_pipeline_forwarding_cpu_top.sv
tb/sv/five_stage_pipeline_forwarding_cpu_top_test.sv
